### design/lfrw_pkg.sv
// Package for the line frame ring writer: payload structs, config register
// indexes, internal widths and the divider state type.
// No dependencies; every other design file refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package lfrw_pkg;

    // Internal widths, fixed by the register widths.
    localparam int ROWS_W  = 13;   // effective frame rows and subframe length
    localparam int BUF_W   = 4;    // effective frames held in the ring
    localparam int TOTAL_W = 17;   // rows in the whole ring
    localparam int RB_W    = 16;   // bytes in one row

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Configuration register indexes.
    localparam logic [2:0] CFG_FRAME_WIDTH     = 3'd0;
    localparam logic [2:0] CFG_BYTES_PER_PIXEL = 3'd1;
    localparam logic [2:0] CFG_FRAME_ROWS      = 3'd2;
    localparam logic [2:0] CFG_SUBFRAME_PARTS  = 3'd3;
    localparam logic [2:0] CFG_BUFFER_FRAMES   = 3'd4;
    localparam logic [2:0] CFG_GRAB_FRAMES     = 3'd5;

    // One input item: a chunk of a detector line.
    typedef struct packed {
        logic [14:0] chunk_bytes;
        logic        line_end;
    } chunk_t;

    // One result item.
    typedef struct packed {
        logic        dropped;
        logic [14:0] write_row;
        logic [13:0] write_offset;
        logic [14:0] write_bytes;
        logic        subframe_ready;
        logic [11:0] subframe_row;
        logic        frame_ready;
        logic [14:0] frame_start_row;
    } result_t;

    // Queue entry: chunk length already clamped to one row.
    typedef struct packed {
        logic [RB_W-1:0] clamped_bytes;
        logic            line_end;
    } qitem_t;

    // Derived ring geometry, stable while items flow.
    typedef struct packed {
        logic [RB_W-1:0]    row_bytes;
        logic [ROWS_W-1:0]  rows;
        logic [TOTAL_W-1:0] total;
        logic [ROWS_W-1:0]  sub_len;
    } geom_t;

    // Strobes from the configuration port to the back.
    typedef struct packed {
        logic        clear_geom;
        logic        load_grab;
        logic [15:0] grab_value;
    } cfg_evt_t;

    // Subframe length divider sequence.
    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_LOAD,
        DIV_STEP,
        DIV_DONE
    } div_state_t;

endpackage

`default_nettype wire

### design/lfrw_cfg.sv
// Configuration registers and derived ring geometry, including a restoring
// divider that finds the subframe length after a geometry write.
// Depends on lfrw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lfrw_cfg #(
    parameter int MAX_ROW_BYTES     = 16384,
    parameter int MAX_FRAME_ROWS    = 4096,
    parameter int MAX_BUFFER_FRAMES = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [15:0]       cfg_data,
    output lfrw_pkg::geom_t        geom,
    output lfrw_pkg::cfg_evt_t     evt,
    output logic                   busy
);

    // Raw register copies.
    logic [12:0] width_reg;
    logic [2:0]  bpp_reg;
    logic [12:0] rows_raw_reg;
    logic [12:0] parts_reg;
    logic [3:0]  bufs_raw_reg;

    lfrw_pkg::div_state_t state_reg, state_next;
    lfrw_pkg::geom_t      geom_reg;

    logic [lfrw_pkg::ROWS_W-1:0] rem_reg, quot_reg, rem_next, quot_next;
    logic [3:0]                  step_reg;
    logic [lfrw_pkg::ROWS_W:0]   rem_shift;
    logic                        rem_ge;

    logic wr, geom_wr;
    logic load_en, step_en, done_en;

    logic [lfrw_pkg::ROWS_W-1:0]  rows_eff;
    logic [lfrw_pkg::BUF_W-1:0]   bufs_eff;
    logic [lfrw_pkg::TOTAL_W-1:0] total_eff;
    logic [lfrw_pkg::RB_W-1:0]    rb_prod, rb_eff;

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid;
    assign geom_wr   = wr && (cfg_index <= lfrw_pkg::CFG_BUFFER_FRAMES);

    // Register writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= 13'd1;
            bpp_reg      <= 3'd2;
            rows_raw_reg <= 13'd1;
            parts_reg    <= 13'd1;
            bufs_raw_reg <= 4'd1;
        end
        else if (wr)
        begin
            case (cfg_index)
                lfrw_pkg::CFG_FRAME_WIDTH:     width_reg    <= cfg_data[12:0];
                lfrw_pkg::CFG_BYTES_PER_PIXEL: bpp_reg      <= cfg_data[2:0];
                lfrw_pkg::CFG_FRAME_ROWS:      rows_raw_reg <= cfg_data[12:0];
                lfrw_pkg::CFG_SUBFRAME_PARTS:  parts_reg    <= cfg_data[12:0];
                lfrw_pkg::CFG_BUFFER_FRAMES:   bufs_raw_reg <= cfg_data[3:0];
                default:                       ;
            endcase
        end
    end

    // Clamp the raw geometry to the supported ranges.
    always_comb
    begin
        if (rows_raw_reg == 13'd0)
            rows_eff = 13'd1;
        else if ({4'd0, rows_raw_reg} > 17'(MAX_FRAME_ROWS))
            rows_eff = 13'(MAX_FRAME_ROWS);
        else
            rows_eff = rows_raw_reg;

        if (bufs_raw_reg == 4'd0)
            bufs_eff = 4'd1;
        else if ({3'd0, bufs_raw_reg} > 7'(MAX_BUFFER_FRAMES))
            bufs_eff = 4'(MAX_BUFFER_FRAMES);
        else
            bufs_eff = bufs_raw_reg;

        total_eff = lfrw_pkg::TOTAL_W'(rows_eff) * lfrw_pkg::TOTAL_W'(bufs_eff);

        rb_prod = lfrw_pkg::RB_W'(width_reg) * lfrw_pkg::RB_W'(bpp_reg);
        if ({1'b0, rb_prod} > 17'(MAX_ROW_BYTES))
            rb_eff = lfrw_pkg::RB_W'(MAX_ROW_BYTES);
        else
            rb_eff = rb_prod;
    end

    // Divider next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lfrw_pkg::DIV_IDLE:
                if (geom_wr) state_next = lfrw_pkg::DIV_LOAD;
            lfrw_pkg::DIV_LOAD:
                if (!geom_wr) state_next = lfrw_pkg::DIV_STEP;
            lfrw_pkg::DIV_STEP:
                if (geom_wr)
                    state_next = lfrw_pkg::DIV_LOAD;
                else if (step_reg == 4'd0)
                    state_next = lfrw_pkg::DIV_DONE;
            lfrw_pkg::DIV_DONE:
                state_next = geom_wr ? lfrw_pkg::DIV_LOAD : lfrw_pkg::DIV_IDLE;
            default:
                state_next = lfrw_pkg::DIV_IDLE;
        endcase
    end

    // Divider outputs.
    always_comb
    begin
        busy    = (state_reg != lfrw_pkg::DIV_IDLE);
        load_en = (state_reg == lfrw_pkg::DIV_LOAD);
        step_en = (state_reg == lfrw_pkg::DIV_STEP);
        done_en = (state_reg == lfrw_pkg::DIV_DONE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= lfrw_pkg::DIV_IDLE;
        else
            state_reg <= state_next;
    end

    // One quotient bit per cycle.
    always_comb
    begin
        rem_shift = {rem_reg, quot_reg[lfrw_pkg::ROWS_W-1]};
        rem_ge    = (rem_shift >= {1'b0, parts_reg});
        rem_next  = rem_ge ? lfrw_pkg::ROWS_W'(rem_shift - {1'b0, parts_reg})
                           : rem_shift[lfrw_pkg::ROWS_W-1:0];
        quot_next = {quot_reg[lfrw_pkg::ROWS_W-2:0], rem_ge};
    end

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            rem_reg  <= '0;
            quot_reg <= rows_eff;
            step_reg <= 4'(lfrw_pkg::ROWS_W - 1);
        end
        else if (step_en)
        begin
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
            step_reg <= step_reg - 4'd1;
        end
    end

    // Derived geometry: clamps at load, subframe length when the divide ends.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            geom_reg.row_bytes <= lfrw_pkg::RB_W'(2);
            geom_reg.rows      <= lfrw_pkg::ROWS_W'(1);
            geom_reg.total     <= lfrw_pkg::TOTAL_W'(1);
            geom_reg.sub_len   <= lfrw_pkg::ROWS_W'(1);
        end
        else if (load_en)
        begin
            geom_reg.row_bytes <= rb_eff;
            geom_reg.rows      <= rows_eff;
            geom_reg.total     <= total_eff;
        end
        else if (done_en)
        begin
            if (parts_reg != 13'd0 && rem_reg == '0)
                geom_reg.sub_len <= quot_reg;
            else
                geom_reg.sub_len <= geom_reg.rows;
        end
    end

    assign geom = geom_reg;

    always_comb
    begin
        evt.clear_geom = geom_wr;
        evt.load_grab  = wr && (cfg_index == lfrw_pkg::CFG_GRAB_FRAMES);
        evt.grab_value = cfg_data;
    end

endmodule

`default_nettype wire

### design/lfrw_front.sv
// Front end: accepts chunks, clamps their length to one row and pushes them
// into the queue. Depends on lfrw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lfrw_front (
    input  wire logic                      chunk_valid,
    output logic                           chunk_stall,
    input  wire lfrw_pkg::chunk_t          chunk,
    input  wire logic [lfrw_pkg::RB_W-1:0] row_bytes,
    input  wire logic                      busy,
    input  wire logic                      queue_full,
    output logic                           push,
    output lfrw_pkg::qitem_t               push_item
);

    logic [lfrw_pkg::RB_W-1:0] bytes_wide;

    // Hold off while the queue is full or the geometry is being derived.
    assign chunk_stall = busy || queue_full;
    assign push        = chunk_valid && !chunk_stall;

    // A chunk can never write more than one row, so clamp it here.
    always_comb
    begin
        bytes_wide              = lfrw_pkg::RB_W'(chunk.chunk_bytes);
        push_item.clamped_bytes = (bytes_wide > row_bytes) ? row_bytes : bytes_wide;
        push_item.line_end      = chunk.line_end;
    end

endmodule

`default_nettype wire

### design/lfrw_queue.sv
// Short register queue between the front and the back.
// Depends on lfrw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lfrw_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  push,
    input  wire lfrw_pkg::qitem_t      push_item,
    input  wire logic                  pop,
    output lfrw_pkg::qitem_t           head,
    output logic                       empty,
    output logic                       full,
    output logic [lfrw_pkg::QCNT_W-1:0] level
);

    lfrw_pkg::qitem_t             slot_reg [lfrw_pkg::QUEUE_DEPTH];
    logic [lfrw_pkg::QPTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [lfrw_pkg::QCNT_W-1:0]  count_reg;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == lfrw_pkg::QCNT_W'(lfrw_pkg::QUEUE_DEPTH));
    assign level = count_reg;
    assign head  = slot_reg[rd_ptr_reg];

    // Storage.
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_item;
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + lfrw_pkg::QPTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + lfrw_pkg::QPTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + lfrw_pkg::QCNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - lfrw_pkg::QCNT_W'(1);
        end
    end

endmodule

`default_nettype wire

### design/lfrw_back.sv
// Back end: places each queued chunk in the row ring, tracks subframe and
// frame completion and the grab count, and holds the result register.
// Depends on lfrw_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lfrw_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire lfrw_pkg::geom_t    geom,
    input  wire lfrw_pkg::cfg_evt_t evt,
    input  wire lfrw_pkg::qitem_t   head,
    input  wire logic               empty,
    output logic                    pop,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output lfrw_pkg::result_t       result
);

    // Ring position state.
    logic [lfrw_pkg::TOTAL_W-1:0] row_idx_reg, row_idx_next;
    logic [lfrw_pkg::RB_W-1:0]    line_pos_reg, line_pos_next;
    logic [lfrw_pkg::ROWS_W-1:0]  sub_row_reg, sub_row_next;
    logic [lfrw_pkg::TOTAL_W-1:0] frame_start_reg, frame_start_next;
    logic [lfrw_pkg::ROWS_W-1:0]  row_in_sub_reg, row_in_sub_next;
    logic [lfrw_pkg::ROWS_W-1:0]  row_in_frame_reg, row_in_frame_next;
    logic [15:0]                  grab_limit_reg, grab_limit_next;
    logic [15:0]                  grabbed_reg, grabbed_next;

    lfrw_pkg::result_t result_reg, result_next;
    logic              result_valid_reg;

    logic                         drop;
    logic [lfrw_pkg::RB_W-1:0]    space, nbytes, offset;
    logic [lfrw_pkg::TOTAL_W-1:0] row_idx_inc;
    logic [lfrw_pkg::ROWS_W-1:0]  sub_inc, frame_inc;
    logic [lfrw_pkg::ROWS_W:0]    sub_row_sum;
    logic [lfrw_pkg::TOTAL_W:0]   frame_start_sum;

    // Take a queued item when the result register is free or being emptied.
    assign pop = !empty && (!result_valid_reg || !result_stall);

    // Per-item step.
    always_comb
    begin
        row_idx_next      = row_idx_reg;
        line_pos_next     = line_pos_reg;
        sub_row_next      = sub_row_reg;
        frame_start_next  = frame_start_reg;
        row_in_sub_next   = row_in_sub_reg;
        row_in_frame_next = row_in_frame_reg;
        grab_limit_next   = grab_limit_reg;
        grabbed_next      = grabbed_reg;
        result_next       = '0;

        drop = (grab_limit_reg != 16'd0) && (grabbed_reg >= grab_limit_reg);

        space  = (line_pos_reg < geom.row_bytes) ? (geom.row_bytes - line_pos_reg) : '0;
        nbytes = (head.clamped_bytes > space) ? space : head.clamped_bytes;
        offset = (space == '0) ? '0 : line_pos_reg;

        row_idx_inc     = row_idx_reg + lfrw_pkg::TOTAL_W'(1);
        sub_inc         = row_in_sub_reg + lfrw_pkg::ROWS_W'(1);
        frame_inc       = row_in_frame_reg + lfrw_pkg::ROWS_W'(1);
        sub_row_sum     = {1'b0, sub_row_reg} + {1'b0, geom.sub_len};
        frame_start_sum = {1'b0, frame_start_reg}
                        + (lfrw_pkg::TOTAL_W + 1)'(geom.rows);

        if (drop)
        begin
            // Grab count reached: discard the chunk and go continuous.
            grab_limit_next     = 16'd0;
            result_next.dropped = 1'b1;
        end
        else
        begin
            result_next.write_row    = row_idx_reg[14:0];
            result_next.write_offset = offset[13:0];
            result_next.write_bytes  = nbytes[14:0];
            line_pos_next            = line_pos_reg + nbytes;

            if (head.line_end)
            begin
                line_pos_next     = '0;
                row_idx_next      = (row_idx_inc == geom.total) ? '0 : row_idx_inc;
                row_in_sub_next   = sub_inc;
                row_in_frame_next = frame_inc;

                // Subframe boundary.
                if (sub_inc >= geom.sub_len)
                begin
                    row_in_sub_next            = '0;
                    result_next.subframe_ready = 1'b1;
                    result_next.subframe_row   = sub_row_reg[11:0];
                    if (sub_row_sum >= {1'b0, geom.rows})
                        sub_row_next = lfrw_pkg::ROWS_W'(sub_row_sum - {1'b0, geom.rows});
                    else
                        sub_row_next = sub_row_sum[lfrw_pkg::ROWS_W-1:0];

                    // Frame boundary.
                    if (frame_inc >= geom.rows)
                    begin
                        row_in_frame_next           = '0;
                        result_next.frame_ready     = 1'b1;
                        result_next.frame_start_row = frame_start_reg[14:0];
                        if (grabbed_reg != 16'hFFFF)
                            grabbed_next = grabbed_reg + 16'd1;
                        if (frame_start_sum >= {1'b0, geom.total})
                            frame_start_next = lfrw_pkg::TOTAL_W'(frame_start_sum
                                                                  - {1'b0, geom.total});
                        else
                            frame_start_next = frame_start_sum[lfrw_pkg::TOTAL_W-1:0];
                    end
                end
            end
        end
    end

    // State update; the user must send configuration strobes only while the pipe is empty (not enforced here).
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_idx_reg      <= '0;
            line_pos_reg     <= '0;
            sub_row_reg      <= '0;
            frame_start_reg  <= '0;
            row_in_sub_reg   <= '0;
            row_in_frame_reg <= '0;
            grab_limit_reg   <= '0;
            grabbed_reg      <= '0;
        end
        else
        begin
            if (evt.clear_geom)
            begin
                row_idx_reg      <= '0;
                line_pos_reg     <= '0;
                sub_row_reg      <= '0;
                frame_start_reg  <= '0;
                row_in_sub_reg   <= '0;
                row_in_frame_reg <= '0;
            end
            else if (pop)
            begin
                row_idx_reg      <= row_idx_next;
                line_pos_reg     <= line_pos_next;
                sub_row_reg      <= sub_row_next;
                frame_start_reg  <= frame_start_next;
                row_in_sub_reg   <= row_in_sub_next;
                row_in_frame_reg <= row_in_frame_next;
            end

            if (evt.load_grab)
            begin
                grab_limit_reg <= evt.grab_value;
                grabbed_reg    <= '0;
            end
            else if (pop)
            begin
                grab_limit_reg <= grab_limit_next;
                grabbed_reg    <= grabbed_next;
            end
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (pop)
            result_valid_reg <= 1'b1;
        else if (!result_stall)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire

### design/line_frame_ring_writer_top.sv
// Top level of the line frame ring writer: configuration, front end, queue
// and back end. Depends on lfrw_pkg and the lfrw_* modules.
//
// Usage:
//   chunk channel  - chunk_valid / chunk_stall carry one item per line chunk
//                    (byte count and an end-of-line flag). An item is taken
//                    when chunk_valid is high and chunk_stall is low.
//   result channel - result_valid / result_stall return one item per chunk:
//                    ring row, byte offset and clamped length, a dropped flag,
//                    and subframe and frame completion with their start rows.
//   cfg channel    - cfg_valid / cfg_ready write register cfg_index with
//                    cfg_data; cfg_ready is always high. Write only while idle.
// Timing: a taken chunk is registered first into the queue, then into the
// result register, and one chunk per cycle is sustained while no stall or
// divide holds the flow; the ring state updates as each chunk leaves the queue.
// A write to any geometry register starts a bit-serial divide for the
// subframe length; chunk_stall stays high meanwhile.
// At reset the geometry is one row of two bytes, one frame, continuous grab.
// When the receiver stalls, the result register holds and the four-entry
// queue keeps taking chunks until it fills; then chunk_stall rises.
`timescale 1ns / 1ps
`default_nettype none

module line_frame_ring_writer_top #(
    parameter int MAX_ROW_BYTES     = 16384,
    parameter int MAX_FRAME_ROWS    = 4096,
    parameter int MAX_BUFFER_FRAMES = 8
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              chunk_valid,
    output logic                   chunk_stall,
    input  wire lfrw_pkg::chunk_t  chunk,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output lfrw_pkg::result_t      result,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [15:0]       cfg_data
);

    lfrw_pkg::geom_t    geom;
    lfrw_pkg::cfg_evt_t evt;
    lfrw_pkg::qitem_t   push_item, head;
    logic               busy, push, pop, empty, full;
    logic [lfrw_pkg::QCNT_W-1:0] level;

    lfrw_cfg #(
        .MAX_ROW_BYTES    (MAX_ROW_BYTES),
        .MAX_FRAME_ROWS   (MAX_FRAME_ROWS),
        .MAX_BUFFER_FRAMES(MAX_BUFFER_FRAMES)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .geom     (geom),
        .evt      (evt),
        .busy     (busy)
    );

    lfrw_front u_front (
        .chunk_valid(chunk_valid),
        .chunk_stall(chunk_stall),
        .chunk      (chunk),
        .row_bytes  (geom.row_bytes),
        .busy       (busy),
        .queue_full (full),
        .push       (push),
        .push_item  (push_item)
    );

    lfrw_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_item(push_item),
        .pop      (pop),
        .head     (head),
        .empty    (empty),
        .full     (full),
        .level    (level)
    );

    lfrw_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .geom        (geom),
        .evt         (evt),
        .head        (head),
        .empty       (empty),
        .pop         (pop),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result      (result)
    );

    // No chunk enters while the subframe length is being derived.
    assert property (@(posedge clk) disable iff (!rst_n) busy |-> !push)
        else $error("chunk accepted during geometry update");

    // The queue fill count never passes its depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        level <= lfrw_pkg::QCNT_W'(lfrw_pkg::QUEUE_DEPTH))
        else $error("queue overflow");

    // The divide only starts after a geometry register write.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(cfg_valid && cfg_ready
                              && cfg_index <= lfrw_pkg::CFG_BUFFER_FRAMES))
        else $error("geometry update without a geometry write");

    // A result only appears after an item left the queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(pop))
        else $error("result without a queued item");

endmodule

`default_nettype wire

### bench/tb_line_frame_ring_writer_top.sv
// Testbench for line_frame_ring_writer_top: a directed table, then random phases of
// line chunks, each result checked against a predictor of the row ring or a table entry.
// Depends on lfrw_pkg and the design files under design/.
`timescale 1ns / 1ps

module tb_line_frame_ring_writer_top;

    // Register indexes that map to nothing.
    localparam logic [2:0] CFG_SPARE_A = 3'd6;
    localparam logic [2:0] CFG_SPARE_B = 3'd7;

    localparam int QUIET_LIMIT   = 2000;
    localparam int MAX_REPORTS   = 40;
    localparam int HOLD_CYCLES   = 48;
    localparam int RANDOM_ITEMS  = 590;
    localparam int TAIL_ITEMS    = 60;
    localparam int DRAIN_CYCLES  = 16;

    typedef enum logic { STEP_REG, STEP_CHUNK } step_kind_t;

    // One row of the directed table.
    typedef struct {
        step_kind_t           kind;
        logic [2:0]           index;
        logic [15:0]          value;
        lfrw_pkg::chunk_t     item;
        bit                   typed;
        lfrw_pkg::result_t    want;
    } plan_step_t;

    logic               clk;
    logic               rst_n;
    logic               chunk_valid;
    logic               chunk_stall;
    lfrw_pkg::chunk_t   chunk_data;
    logic               result_valid;
    logic               result_stall;
    lfrw_pkg::result_t  result_data;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [2:0]         cfg_index;
    logic [15:0]        cfg_data;

    // Register copies and ring state of the predictor.
    int unsigned set_width, set_bpp, set_rows, set_parts, set_bufs;
    int unsigned ring_row, line_pos, sub_start, frm_start;
    int unsigned rows_into_sub, rows_into_frm, sub_len;
    int unsigned grab_limit, grab_count;

    lfrw_pkg::result_t ring_writes_q[$];
    plan_step_t        directed_plan[$];

    int unsigned items_placed   = 0;
    int unsigned drops_seen     = 0;
    int unsigned subframes_seen = 0;
    int unsigned frames_seen    = 0;
    int unsigned results_seen   = 0;
    int unsigned errors         = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_idle_pct  = 0;
    bit          hold_request   = 1'b0;

    line_frame_ring_writer_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .chunk_valid  (chunk_valid),
        .chunk_stall  (chunk_stall),
        .chunk        (chunk_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Effective rows per frame, with zero and oversize values folded in.
    function automatic int unsigned rows_in_frame();
        if (set_rows < 1) return 1;
        if (set_rows > 4096) return 4096;
        return set_rows;
    endfunction

    // Bytes in one ring row, capped at the row size limit.
    function automatic int unsigned row_bytes();
        int unsigned rb;
        rb = set_width * set_bpp;
        return (rb > 16384) ? 16384 : rb;
    endfunction

    // A geometry change derives the subframe length and rewinds the ring.
    function automatic void restart_geometry();
        int unsigned rows;
        rows = rows_in_frame();
        if (set_parts != 0 && (rows % set_parts) == 0)
            sub_len = rows / set_parts;
        else
            sub_len = rows;
        ring_row      = 0;
        line_pos      = 0;
        sub_start     = 0;
        frm_start     = 0;
        rows_into_sub = 0;
        rows_into_frm = 0;
    endfunction

    function automatic void apply_register(input logic [2:0] idx, input logic [15:0] value);
        case (idx)
            lfrw_pkg::CFG_FRAME_WIDTH:
            begin
                set_width = 32'(value[12:0]);
                restart_geometry();
            end
            lfrw_pkg::CFG_BYTES_PER_PIXEL:
            begin
                set_bpp = 32'(value[2:0]);
                restart_geometry();
            end
            lfrw_pkg::CFG_FRAME_ROWS:
            begin
                set_rows = 32'(value[12:0]);
                restart_geometry();
            end
            lfrw_pkg::CFG_SUBFRAME_PARTS:
            begin
                set_parts = 32'(value[12:0]);
                restart_geometry();
            end
            lfrw_pkg::CFG_BUFFER_FRAMES:
            begin
                set_bufs = 32'(value[3:0]);
                restart_geometry();
            end
            lfrw_pkg::CFG_GRAB_FRAMES:
            begin
                grab_limit = 32'(value);
                grab_count = 0;
            end
            default: ;
        endcase
    endfunction

    // Works out the ring write for one chunk and advances the ring state.
    function automatic void place_chunk(input lfrw_pkg::chunk_t c,
                                        output lfrw_pkg::result_t r);
        int unsigned rows, bufs, total, rb, space, nbytes, start_row, bytes_in;
        r = '0;
        // Grab count reached: this chunk is dropped and grabbing turns continuous.
        if (grab_limit != 0 && grab_count >= grab_limit)
        begin
            grab_limit = 0;
            r.dropped  = 1'b1;
            drops_seen++;
            return;
        end
        rows  = rows_in_frame();
        bufs  = (set_bufs < 1) ? 1 : ((set_bufs > 8) ? 8 : set_bufs);
        total = rows * bufs;
        rb    = row_bytes();

        // Clamp to the room left in the row; a full row writes nothing.
        bytes_in = 32'(c.chunk_bytes);
        space    = (line_pos < rb) ? (rb - line_pos) : 0;
        nbytes   = (bytes_in > space) ? space : bytes_in;
        r.write_row    = ring_row[14:0];
        r.write_offset = (space == 0) ? 14'd0 : line_pos[13:0];
        r.write_bytes  = nbytes[14:0];
        line_pos += nbytes;

        // Line end moves to the next ring row and may close a subframe and a frame.
        if (c.line_end)
        begin
            line_pos = 0;
            ring_row = (ring_row + 1) % total;
            rows_into_sub++;
            rows_into_frm++;
            if (rows_into_sub >= sub_len)
            begin
                rows_into_sub    = 0;
                start_row        = sub_start % rows;
                r.subframe_ready = 1'b1;
                r.subframe_row   = start_row[11:0];
                sub_start        = (sub_start + sub_len) % total;
                subframes_seen++;
                if (rows_into_frm >= rows)
                begin
                    rows_into_frm     = 0;
                    r.frame_ready     = 1'b1;
                    r.frame_start_row = frm_start[14:0];
                    if (grab_count < 65535) grab_count++;
                    frm_start = (frm_start + rows) % total;
                    frames_seen++;
                end
            end
        end
    endfunction

    function automatic void add_reg(input logic [2:0] idx, input logic [15:0] value);
        plan_step_t s;
        s       = '{kind: STEP_REG, default: '0};
        s.index = idx;
        s.value = value;
        directed_plan.push_back(s);
    endfunction

    function automatic void add_checked(input int unsigned bytes, input bit ends_line,
                                        input bit typed, input lfrw_pkg::result_t want);
        plan_step_t s;
        s                  = '{kind: STEP_CHUNK, default: '0};
        s.item.chunk_bytes = bytes[14:0];
        s.item.line_end    = ends_line;
        s.typed            = typed;
        s.want             = want;
        directed_plan.push_back(s);
    endfunction

    function automatic void add_chunk(input int unsigned bytes, input bit ends_line);
        add_checked(bytes, ends_line, 1'b0, '0);
    endfunction

    // Offers one item, waits for it to be taken, then records its expected write.
    task automatic offer_chunk(input lfrw_pkg::chunk_t c, input bit typed,
                               input lfrw_pkg::result_t want);
        lfrw_pkg::result_t predicted;
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
        begin
            chunk_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        chunk_valid <= 1'b1;
        chunk_data  <= c;
        @(posedge clk);
        while (chunk_stall) @(posedge clk);
        place_chunk(c, predicted);
        if (!predicted.dropped) items_placed++;
        ring_writes_q.push_back(typed ? want : predicted);
    endtask

    // Stops offering and waits until every expected write has come back.
    task automatic settle();
        chunk_valid <= 1'b0;
        while (ring_writes_q.size() != 0) @(posedge clk);
    endtask

    // Register write while idle; waits out the subframe length divide after it.
    task automatic write_register(input logic [2:0] idx, input logic [15:0] value);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        apply_register(idx, value);
        cfg_valid <= 1'b0;
        @(posedge clk);
        while (chunk_stall) @(posedge clk);
    endtask

    // Writes a register half the time, mostly with a small legal value.
    task automatic maybe_write(input logic [2:0] idx, input int unsigned lo, input int unsigned hi);
        logic [15:0] value;
        if ($urandom_range(0, 1) == 0) return;
        if ($urandom_range(0, 9) == 0)
            value = 16'($urandom_range(0, 65535));
        else
            value = 16'($urandom_range(lo, hi));
        write_register(idx, value);
    endtask

    // Mostly well-formed lines with random chunking; the rest overruns and noise.
    task automatic run_random_phase(input int unsigned count);
        int unsigned      first, rb, room, bytes, pick;
        lfrw_pkg::chunk_t c;
        first = items_placed;
        while (items_placed - first < count)
        begin
            rb   = row_bytes();
            room = (line_pos < rb) ? (rb - line_pos) : 0;
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                if (room == 0)
                    bytes = 0;
                else if ($urandom_range(0, 2) == 0)
                    bytes = room;
                else
                    bytes = $urandom_range(1, room);
                c.chunk_bytes = bytes[14:0];
                c.line_end    = (bytes == room);
            end
            else if (pick < 85)
            begin
                bytes         = room + $urandom_range(0, 40);
                c.chunk_bytes = bytes[14:0];
                c.line_end    = 1'($urandom_range(0, 1));
            end
            else
            begin
                c.chunk_bytes = 15'($urandom_range(0, 32767));
                c.line_end    = 1'($urandom_range(0, 1));
            end
            offer_chunk(c, 1'b0, '0);
        end
    endtask

    function automatic int unsigned idle_rate();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 15;
            default: return 40;
        endcase
    endfunction

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want)
        begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // Result side: checks each accepted item and drives the stall pattern.
    initial
    begin : result_sink
        lfrw_pkg::result_t want;
        int unsigned       burst_left;
        int unsigned       hold_left;
        burst_left = 0;
        hold_left  = 0;
        result_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_valid && !result_stall)
            begin
                results_seen++;
                if (ring_writes_q.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("%0t ns: no write expected, got %h", $time, result_data);
                end
                else
                begin
                    want = ring_writes_q.pop_front();
                    compare_field("dropped", 32'(want.dropped),
                                  32'(result_data.dropped));
                    compare_field("write_row", 32'(want.write_row),
                                  32'(result_data.write_row));
                    compare_field("write_offset", 32'(want.write_offset),
                                  32'(result_data.write_offset));
                    compare_field("write_bytes", 32'(want.write_bytes),
                                  32'(result_data.write_bytes));
                    compare_field("subframe_ready", 32'(want.subframe_ready),
                                  32'(result_data.subframe_ready));
                    compare_field("subframe_row", 32'(want.subframe_row),
                                  32'(result_data.subframe_row));
                    compare_field("frame_ready", 32'(want.frame_ready),
                                  32'(result_data.frame_ready));
                    compare_field("frame_start_row", 32'(want.frame_start_row),
                                  32'(result_data.frame_start_row));
                end
            end
            // Long hold first, then random stall bursts.
            if (hold_left != 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES - 1;
                result_stall <= 1'b1;
            end
            else if (burst_left != 0)
            begin
                burst_left--;
                result_stall <= 1'b1;
            end
            else if (recv_idle_pct != 0 && $urandom_range(0, 99) < recv_idle_pct)
            begin
                burst_left = $urandom_range(0, 5);
                result_stall <= 1'b1;
            end
            else
            begin
                result_stall <= 1'b0;
            end
        end
    end

    // Watchdog on cycles with no handshake on any channel.
    initial
    begin : watchdog
        int unsigned quiet;
        quiet = 0;
        forever
        begin
            @(posedge clk);
            if ((chunk_valid && !chunk_stall) || (result_valid && !result_stall) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("%0t ns: no handshake for %0d cycles", $time, quiet);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Stimulus: reset, directed table, random phases, drain and verdict.
    initial
    begin : stimulus
        lfrw_pkg::result_t row_closed;
        lfrw_pkg::result_t dropped_item;
        int unsigned       phases;
        int unsigned       random_first;
        int unsigned       count;

        chunk_valid <= 1'b0;
        chunk_data  <= '0;
        cfg_valid   <= 1'b0;
        cfg_index   <= '0;
        cfg_data    <= '0;
        rst_n       <= 1'b0;

        // Reset state of the predictor: one row of two bytes, continuous grab.
        set_width  = 1;
        set_bpp    = 2;
        set_rows   = 1;
        set_parts  = 1;
        set_bufs   = 1;
        grab_limit = 0;
        grab_count = 0;
        restart_geometry();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A whole two-byte row that closes a one-row subframe and frame.
        row_closed                = '0;
        row_closed.write_bytes    = 15'd2;
        row_closed.subframe_ready = 1'b1;
        row_closed.frame_ready    = 1'b1;
        dropped_item              = '0;
        dropped_item.dropped      = 1'b1;

        // Reset geometry: empty chunk, oversize line end, filling and overfilling the row.
        add_checked(0, 1'b0, 1'b1, '0);
        add_checked(32767, 1'b1, 1'b1, row_closed);
        add_chunk(1, 1'b0);
        add_chunk(5, 1'b0);
        add_checked(3, 1'b0, 1'b1, '0);
        add_chunk(0, 1'b1);
        // Grab two frames; the third item is dropped, then grabbing is continuous.
        add_reg(lfrw_pkg::CFG_GRAB_FRAMES, 16'd2);
        add_chunk(2, 1'b1);
        add_chunk(2, 1'b1);
        add_checked(7, 1'b1, 1'b1, dropped_item);
        add_chunk(2, 1'b1);
        // Oversize row bytes with masked register data, subframes of two rows.
        add_reg(lfrw_pkg::CFG_FRAME_WIDTH, 16'hFFFF);
        add_reg(lfrw_pkg::CFG_BYTES_PER_PIXEL, 16'hFFFF);
        add_reg(lfrw_pkg::CFG_FRAME_ROWS, 16'd6);
        add_reg(lfrw_pkg::CFG_SUBFRAME_PARTS, 16'd3);
        add_reg(lfrw_pkg::CFG_BUFFER_FRAMES, 16'd0);
        add_chunk(16384, 1'b0);
        add_checked(32767, 1'b0, 1'b1, '0);
        add_chunk(0, 1'b1);
        add_chunk(100, 1'b1);
        // Frame rows past the cap, zero parts, buffer frames past the cap.
        add_reg(lfrw_pkg::CFG_FRAME_ROWS, 16'hFFFF);
        add_reg(lfrw_pkg::CFG_SUBFRAME_PARTS, 16'd0);
        add_reg(lfrw_pkg::CFG_BUFFER_FRAMES, 16'hFFFF);
        add_chunk(16383, 1'b1);
        add_chunk(1, 1'b1);
        // Zero-byte rows.
        add_reg(lfrw_pkg::CFG_FRAME_WIDTH, 16'd0);
        add_checked(32767, 1'b1, 1'b1, '0);
        add_reg(lfrw_pkg::CFG_BYTES_PER_PIXEL, 16'd0);
        add_reg(lfrw_pkg::CFG_FRAME_WIDTH, 16'd4096);
        add_chunk(5, 1'b0);
        // Unmapped indexes change nothing.
        add_reg(CFG_SPARE_A, 16'hFFFF);
        add_reg(CFG_SPARE_B, 16'hFFFF);
        // Largest legal row, eight one-row frames, parts that do not divide.
        add_reg(lfrw_pkg::CFG_BYTES_PER_PIXEL, 16'd4);
        add_reg(lfrw_pkg::CFG_FRAME_ROWS, 16'd1);
        add_reg(lfrw_pkg::CFG_SUBFRAME_PARTS, 16'd4096);
        add_reg(lfrw_pkg::CFG_BUFFER_FRAMES, 16'd8);
        add_chunk(16384, 1'b1);
        add_chunk(16385, 1'b1);
        add_chunk(0, 1'b1);
        add_reg(lfrw_pkg::CFG_GRAB_FRAMES, 16'hFFFF);
        add_chunk(1, 1'b1);
        // One-row subframes in a four-row frame.
        add_reg(lfrw_pkg::CFG_GRAB_FRAMES, 16'd0);
        add_reg(lfrw_pkg::CFG_FRAME_ROWS, 16'd4);
        add_reg(lfrw_pkg::CFG_SUBFRAME_PARTS, 16'd4);
        add_reg(lfrw_pkg::CFG_FRAME_WIDTH, 16'd4);
        add_reg(lfrw_pkg::CFG_BYTES_PER_PIXEL, 16'd1);
        add_reg(lfrw_pkg::CFG_BUFFER_FRAMES, 16'd2);
        add_chunk(4, 1'b1);
        add_chunk(2, 1'b0);
        add_chunk(2, 1'b1);

        send_idle_pct = 20;
        recv_idle_pct = 20;
        foreach (directed_plan[k])
        begin
            if (directed_plan[k].kind == STEP_REG)
                write_register(directed_plan[k].index, directed_plan[k].value);
            else
                offer_chunk(directed_plan[k].item, directed_plan[k].typed,
                            directed_plan[k].want);
        end

        // Random phases, each with fresh registers and idle rates.
        phases       = 0;
        random_first = items_placed;
        while (items_placed - random_first < RANDOM_ITEMS)
        begin
            maybe_write(lfrw_pkg::CFG_FRAME_WIDTH, 1, 24);
            maybe_write(lfrw_pkg::CFG_BYTES_PER_PIXEL, 1, 4);
            maybe_write(lfrw_pkg::CFG_FRAME_ROWS, 1, 12);
            maybe_write(lfrw_pkg::CFG_SUBFRAME_PARTS, 1, 6);
            maybe_write(lfrw_pkg::CFG_BUFFER_FRAMES, 1, 4);
            if ($urandom_range(0, 2) == 0)
                write_register(lfrw_pkg::CFG_GRAB_FRAMES, 16'($urandom_range(0, 4)));
            send_idle_pct = idle_rate();
            recv_idle_pct = idle_rate();
            count         = $urandom_range(20, 60);
            // One phase fills the block behind a long receiver hold.
            if (phases == 2)
            begin
                send_idle_pct = 0;
                count         = 50;
                hold_request  = 1'b1;
            end
            run_random_phase(count);
            phases++;
        end

        // Closing stretch at full rate on both sides.
        settle();
        write_register(lfrw_pkg::CFG_GRAB_FRAMES, 16'd0);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_phase(TAIL_ITEMS);
        phases++;

        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d results: %0d placed chunks, %0d dropped,",
                 results_seen, items_placed, drops_seen);
        $display("%0d subframes and %0d frames closed in the ring.",
                 subframes_seen, frames_seen);
        $display("Ran the directed table and %0d random register phases",
                 phases);
        $display("with stalls on both sides and one long receiver hold.");
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
